// ===== design/fdtp_pkg.sv =====
package fdtp_pkg;

   // Structure block tokens, host byte order
   localparam logic [31:0] TOK_BEGIN_NODE = 32'h0000_0001;
   localparam logic [31:0] TOK_END_NODE   = 32'h0000_0002;
   localparam logic [31:0] TOK_PROP       = 32'h0000_0003;
   localparam logic [31:0] TOK_NOP        = 32'h0000_0004;
   localparam logic [31:0] TOK_END        = 32'h0000_0009;

   localparam int          MAX_DEPTH_DEFAULT = 15;
   localparam logic [23:0] LIMIT_RESET       = 24'hFF_FFFF;

   typedef enum logic [2:0] {
      PH_TOKEN   = 3'd0,
      PH_NAME    = 3'd1,
      PH_LEN     = 3'd2,
      PH_NAMEOFF = 3'd3,
      PH_DATA    = 3'd4
   } phase_type;

   typedef enum logic [3:0] {
      K_BEGIN   = 4'd0,
      K_NAME    = 4'd1,
      K_ENDNODE = 4'd2,
      K_PROP    = 4'd3,
      K_LENGTH  = 4'd4,
      K_NAMEOFF = 4'd5,
      K_DATA    = 4'd6,
      K_NOP     = 4'd7,
      K_END     = 4'd8,
      K_ERROR   = 4'd9,
      K_IGNORED = 4'd10
   } kind_type;

   typedef struct packed {
      phase_type   phase;
      logic [31:0] bytes_left;
      logic [3:0]  nesting;
      logic [23:0] words_seen;
      logic [31:0] held_length;
      logic [31:0] held_offset;
      logic        stopped;
   } parse_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  depth;
      logic [31:0] prop_length;
      logic [31:0] name_offset;
      logic [31:0] value_word;
      logic [2:0]  valid_bytes;
      logic        last;
   } result_type;

   function automatic logic [31:0] swap32(input logic [31:0] w);
      return {w[7:0], w[15:8], w[23:16], w[31:24]};
   endfunction

endpackage

// ===== design/fdtp_step.sv =====
module fdtp_step
   import fdtp_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  parse_state_type state_i,
   input  logic [31:0]     raw_word_i,
   input  logic            restart_i,
   input  logic [23:0]     limit_i,
   output parse_state_type state_o,
   output result_type      result_o
);

   localparam logic [3:0] DepthCap = (MAX_DEPTH < 15) ? 4'(MAX_DEPTH) : 4'd15;

   parse_state_type cur;
   parse_state_type nxt;
   logic [31:0]     w;
   kind_type        kind;
   logic [2:0]      valid;
   logic [2:0]      name_len;
   logic            last;

   assign w = swap32(raw_word_i);

   // Count name characters ahead of the first zero byte
   always_comb begin
      if (w[31:24] == 8'd0) begin
         name_len = 3'd0;
      end else if (w[23:16] == 8'd0) begin
         name_len = 3'd1;
      end else if (w[15:8] == 8'd0) begin
         name_len = 3'd2;
      end else if (w[7:0] == 8'd0) begin
         name_len = 3'd3;
      end else begin
         name_len = 3'd4;
      end
   end

   always_comb begin
      cur = state_i;
      if (restart_i) begin
         cur.phase       = PH_TOKEN;
         cur.bytes_left  = '0;
         cur.nesting     = '0;
         cur.words_seen  = '0;
         cur.held_length = '0;
         cur.held_offset = '0;
         cur.stopped     = 1'b0;
      end
      nxt   = cur;
      kind  = K_IGNORED;
      valid = 3'd0;
      last  = 1'b0;
      if (!cur.stopped && (cur.words_seen < limit_i)) begin
         nxt.words_seen = cur.words_seen + 24'd1;
         case (cur.phase)
            PH_NAME: begin
               kind  = K_NAME;
               valid = name_len;
               if (name_len != 3'd4) begin
                  last      = 1'b1;
                  nxt.phase = PH_TOKEN;
               end
            end
            PH_LEN: begin
               kind            = K_LENGTH;
               nxt.held_length = w;
               nxt.phase       = PH_NAMEOFF;
            end
            PH_NAMEOFF: begin
               kind            = K_NAMEOFF;
               nxt.held_offset = w;
               nxt.bytes_left  = cur.held_length;
               nxt.phase       = (cur.held_length == 32'd0) ? PH_TOKEN : PH_DATA;
            end
            PH_DATA: begin
               kind           = K_DATA;
               valid          = (cur.bytes_left < 32'd4) ? cur.bytes_left[2:0] : 3'd4;
               nxt.bytes_left = cur.bytes_left - {29'd0, valid};
               if (cur.bytes_left <= 32'd4) begin
                  last      = 1'b1;
                  nxt.phase = PH_TOKEN;
               end
            end
            default: begin
               nxt.phase = PH_TOKEN;
               case (w)
                  TOK_BEGIN_NODE: begin
                     kind      = K_BEGIN;
                     nxt.phase = PH_NAME;
                     if (cur.nesting < DepthCap) begin
                        nxt.nesting = cur.nesting + 4'd1;
                     end
                  end
                  TOK_END_NODE: begin
                     if (cur.nesting == 4'd0) begin
                        kind        = K_ERROR;
                        nxt.stopped = 1'b1;
                     end else begin
                        kind        = K_ENDNODE;
                        nxt.nesting = cur.nesting - 4'd1;
                     end
                  end
                  TOK_PROP: begin
                     kind      = K_PROP;
                     nxt.phase = PH_LEN;
                  end
                  TOK_NOP: begin
                     kind = K_NOP;
                  end
                  TOK_END: begin
                     kind        = K_END;
                     nxt.stopped = 1'b1;
                  end
                  default: begin
                     kind        = K_ERROR;
                     nxt.stopped = 1'b1;
                  end
               endcase
            end
         endcase
      end
   end

   assign state_o              = nxt;
   assign result_o.kind        = kind;
   assign result_o.depth       = nxt.nesting;
   assign result_o.prop_length = nxt.held_length;
   assign result_o.name_offset = nxt.held_offset;
   assign result_o.value_word  = w;
   assign result_o.valid_bytes = valid;
   assign result_o.last        = last;

endmodule

// ===== design/fdt_structure_token_parser.sv =====
// Flattened device tree structure block parser. Feed the structure block one raw
// big-endian memory word per transaction; each word yields exactly one result
// transaction carrying the byte-swapped word, its classification (begin-node,
// name, end-node, prop, length, name offset, data, nop, end, error, ignored),
// the nesting depth after the word, the held length and name offset of the
// current property, and for name and data words the count of meaningful bytes
// and a last flag. Set req_restart on the first word of a new block. After an
// end token, an error, or once csr_wr_data's limit of words has been examined,
// words come back as ignored until the next restart. One word is taken every
// cycle: the whole classification and state update sits between the parse
// state registers and the single result register, and input is stalled only
// while that result register is full and its consumer stalls.
// Write the limit register only while the block is idle.
module fdt_structure_token_parser
   import fdtp_pkg::*;
#(
   parameter int MAX_DEPTH = MAX_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // input word channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_raw_word,
   input  logic        req_restart,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_kind,
   output logic [3:0]  rsp_depth,
   output logic [31:0] rsp_prop_length,
   output logic [31:0] rsp_name_offset,
   output logic [31:0] rsp_value_word,
   output logic [2:0]  rsp_valid_bytes,
   output logic        rsp_last,
   // limit register
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_ff;
   result_type      result_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [23:0]     limit_ff;
   logic            req_take;

   // Hold input while a finished result is still waiting downstream
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   fdtp_step #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_step (
      .state_i    (state_ff),
      .raw_word_i (req_raw_word),
      .restart_i  (req_restart),
      .limit_i    (limit_ff),
      .state_o    (state_in),
      .result_o   (result_in)
   );

   // Result register fills on each accepted word, drains when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff         <= 1'b0;
         limit_ff             <= LIMIT_RESET;
         state_ff.phase       <= PH_TOKEN;
         state_ff.bytes_left  <= '0;
         state_ff.nesting     <= '0;
         state_ff.words_seen  <= '0;
         state_ff.held_length <= '0;
         state_ff.held_offset <= '0;
         state_ff.stopped     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload register: no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = result_ff.kind;
   assign rsp_depth       = result_ff.depth;
   assign rsp_prop_length = result_ff.prop_length;
   assign rsp_name_offset = result_ff.name_offset;
   assign rsp_value_word  = result_ff.value_word;
   assign rsp_valid_bytes = result_ff.valid_bytes;
   assign rsp_last        = result_ff.last;

`ifndef SYNTH
   // A stopped parser reports ignored unless restarted
   a_stopped_ignored : assert property (@(posedge clock) disable iff (reset)
      (req_take && state_ff.stopped && !req_restart) |=> (rsp_kind == K_IGNORED))
      else $error("stopped parser did not report ignored");

   // Byte counts and last flag belong to name and data words only
   a_bytes_kind : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_valid_bytes != 3'd0 || rsp_last)) |->
         (rsp_kind == K_NAME || rsp_kind == K_DATA))
      else $error("byte count or last on a non-payload word");

   // Depth never passes the cap
   a_depth_cap : assert property (@(posedge clock) disable iff (reset)
      (state_ff.nesting <= 4'd15) && (MAX_DEPTH >= 15 || state_ff.nesting <= 4'(MAX_DEPTH)))
      else $error("nesting depth above cap");

   // Input stalls only behind a full, stalled result register
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without back-pressure");

   // Data words never exceed four meaningful bytes
   a_data_bytes : assert property (@(posedge clock) disable iff (reset)
      req_take && state_ff.phase == PH_DATA && !state_ff.stopped && !req_restart &&
         state_ff.words_seen < limit_ff |=> (rsp_valid_bytes != 3'd0 && rsp_valid_bytes <= 3'd4))
      else $error("bad data byte count");
`endif

endmodule

// ===== verif/fdt_structure_token_parser_tb.sv =====
module fdt_structure_token_parser_tb;
   import fdtp_pkg::*;

   // Nesting stops counting up at the lesser of the depth parameter and the
   // four-bit depth field.
   localparam int DEPTH_CAP = (MAX_DEPTH_DEFAULT < 15) ? MAX_DEPTH_DEFAULT : 15;
   localparam int LONG_HOLD = 300;   // cycles the receiver holds off once
   localparam int SETTLE    = 4;     // cycles to idle after the last result
   localparam int PRINT_CAP = 40;    // mismatch lines printed before going quiet

   // One row of the directed table. Where typed is set, want is the result
   // written out by hand; otherwise the predictor supplies it.
   typedef struct packed {
      logic [31:0] raw;
      logic        restart;
      logic        typed;
      result_type  want;
   } dir_row_type;

   // Receiver stall patterns, switched at random intervals.
   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_LIGHT,
      FLOW_HEAVY,
      FLOW_PERIODIC
   } flow_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_raw_word = '0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_kind;
   logic [3:0]  rsp_depth;
   logic [31:0] rsp_prop_length;
   logic [31:0] rsp_name_offset;
   logic [31:0] rsp_value_word;
   logic [2:0]  rsp_valid_bytes;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   // Parser state as the predictor sees it
   logic [23:0] limit_words = LIMIT_RESET;
   phase_type   pr_phase;
   logic [31:0] pr_bytes_left;
   logic [3:0]  pr_depth;
   logic [23:0] pr_seen;
   logic [31:0] pr_len;
   logic [31:0] pr_off;
   logic        pr_halted;

   // Results the block owes us, oldest first
   result_type  pending_results[$];

   dir_row_type dir_rows[25];
   int          burst_left = 0;
   int          words_sent = 0;
   int          parsed_words = 0;
   int          results_checked = 0;
   int          mismatches = 0;
   int          deepest = 0;
   int          kind_seen[16];
   int          small_limit;
   bit          hold_req = 1'b0;
   bit          hold_done = 1'b0;
   int          hold_left = 0;
   int          mode_left = 0;
   flow_mode_type flow_mode = FLOW_FREE;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   fdt_structure_token_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_word    (req_raw_word),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_depth       (rsp_depth),
      .rsp_prop_length (rsp_prop_length),
      .rsp_name_offset (rsp_name_offset),
      .rsp_value_word  (rsp_value_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_last        (rsp_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   // Memory order and host order differ by a full byte reversal.
   function automatic logic [31:0] byte_rev(input logic [31:0] x);
      logic [31:0] y;
      for (int i = 0; i < 4; i++) y[8*i +: 8] = x[8*(3-i) +: 8];
      return y;
   endfunction

   // Wipe the parse state; the limit register survives.
   task automatic clear_parse_state();
      pr_phase      = PH_TOKEN;
      pr_bytes_left = '0;
      pr_depth      = '0;
      pr_seen       = '0;
      pr_len        = '0;
      pr_off        = '0;
      pr_halted     = 1'b0;
   endtask

   // Advance the parse state by one structure word and work out its result.
   task automatic predict_word(input logic [31:0] raw, input logic restart,
                               output result_type r);
      logic [31:0] w;
      logic [2:0]  nb;
      int          n;
      w = byte_rev(raw);
      r.kind        = K_IGNORED;
      r.valid_bytes = '0;
      r.last        = 1'b0;
      if (restart) clear_parse_state();
      if (!pr_halted && pr_seen < limit_words) begin
         pr_seen++;
         case (pr_phase)
            PH_NAME: begin
               // count characters up to the first zero byte in memory order
               n = 4;
               for (int i = 0; i < 4; i++) if (w[8*i +: 8] == 8'h00) n = 3 - i;
               r.kind        = K_NAME;
               r.valid_bytes = 3'(n);
               if (n < 4) begin
                  r.last   = 1'b1;
                  pr_phase = PH_TOKEN;
               end
            end
            PH_LEN: begin
               pr_len   = w;
               r.kind   = K_LENGTH;
               pr_phase = PH_NAMEOFF;
            end
            PH_NAMEOFF: begin
               pr_off        = w;
               r.kind        = K_NAMEOFF;
               pr_bytes_left = pr_len;
               pr_phase      = (pr_len == 0) ? PH_TOKEN : PH_DATA;
            end
            PH_DATA: begin
               nb             = (pr_bytes_left < 4) ? pr_bytes_left[2:0] : 3'd4;
               r.kind         = K_DATA;
               r.valid_bytes  = nb;
               pr_bytes_left  = pr_bytes_left - {29'd0, nb};
               if (pr_bytes_left == 0) begin
                  r.last   = 1'b1;
                  pr_phase = PH_TOKEN;
               end
            end
            default: begin
               pr_phase = PH_TOKEN;
               case (w)
                  TOK_BEGIN_NODE: begin
                     r.kind = K_BEGIN;
                     if (pr_depth < DEPTH_CAP) pr_depth++;
                     pr_phase = PH_NAME;
                  end
                  TOK_END_NODE: begin
                     if (pr_depth == 0) begin
                        r.kind    = K_ERROR;
                        pr_halted = 1'b1;
                     end else begin
                        r.kind = K_ENDNODE;
                        pr_depth--;
                     end
                  end
                  TOK_PROP: begin
                     r.kind   = K_PROP;
                     pr_phase = PH_LEN;
                  end
                  TOK_NOP: r.kind = K_NOP;
                  TOK_END: begin
                     r.kind    = K_END;
                     pr_halted = 1'b1;
                  end
                  default: begin
                     r.kind    = K_ERROR;
                     pr_halted = 1'b1;
                  end
               endcase
            end
         endcase
      end
      r.depth       = pr_depth;
      r.prop_length = pr_len;
      r.name_offset = pr_off;
      r.value_word  = w;
   endtask

   // Offer one word and hold it until the block takes it. The sender runs in
   // bursts; between bursts drop valid for a random gap. Once the transaction
   // is accepted, queue its predicted result.
   task automatic send_word(input logic [31:0] raw, input logic restart);
      result_type r;
      int         gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_raw_word <= raw;
      req_restart  <= restart;
      do @(posedge clock); while (req_stall);
      predict_word(raw, restart, r);
      pending_results.push_back(r);
      words_sent++;
      kind_seen[r.kind]++;
      if (r.kind != K_IGNORED) parsed_words++;
      if (r.depth > deepest) deepest = r.depth;
   endtask

   // Node name: up to eleven characters, the zero byte, and padding that is
   // sometimes left as junk after the terminator.
   task automatic send_name();
      int          chars;
      int          idx;
      bit          junk;
      logic [31:0] w;
      chars = $urandom_range(0, 11);
      junk  = 1'($urandom_range(0, 1));
      for (int i = 0; i <= chars / 4; i++) begin
         for (int b = 0; b < 4; b++) begin
            idx = 4 * i + b;
            if (idx < chars) w[8*(3-b) +: 8] = 8'($urandom_range(1, 255));
            else if (idx == chars || !junk) w[8*(3-b) +: 8] = 8'h00;
            else w[8*(3-b) +: 8] = 8'($urandom);
         end
         send_word(byte_rev(w), 1'b0);
      end
   endtask

   // Property: token, length, name offset, then the padded data words. A rare
   // huge length leaves the parser in the data phase for the rest of the block.
   task automatic send_property();
      logic [31:0] len;
      int          nwords;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) len = '0;
      else if (pick < 80) len = $urandom_range(1, 16);
      else if (pick < 97) len = $urandom_range(17, 64);
      else len = $urandom;
      nwords = (len > 240) ? 60 : int'((len + 3) / 4);
      send_word(byte_rev(TOK_PROP), 1'b0);
      send_word(byte_rev(len), 1'b0);
      send_word($urandom, 1'b0);
      repeat (nwords) send_word($urandom, 1'b0);
   endtask

   // One structure block: restart on a begin-node, a random walk over nodes,
   // properties and nops, mostly closed off cleanly with an end token. Noise
   // words and stray end-nodes break some blocks early.
   task automatic send_block();
      int walk_depth;
      int pick;
      int steps;
      bit deep;
      deep       = ($urandom_range(0, 5) == 0);
      steps      = $urandom_range(4, 40);
      walk_depth = 1;
      send_word(byte_rev(TOK_BEGIN_NODE), 1'b1);
      send_name();
      repeat (steps) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_word($urandom, 1'b0);
         end else if (pick < (deep ? 75 : 35)) begin
            send_word(byte_rev(TOK_BEGIN_NODE), 1'b0);
            send_name();
            walk_depth++;
         end else if (pick < 80) begin
            send_property();
         end else if (pick < 87) begin
            send_word(byte_rev(TOK_NOP), 1'b0);
         end else begin
            // at depth zero this closes a node that was never opened
            send_word(byte_rev(TOK_END_NODE), 1'b0);
            if (walk_depth > 0) walk_depth--;
         end
      end
      if ($urandom_range(0, 4) != 0) begin
         while (walk_depth > 0) begin
            send_word(byte_rev(TOK_END_NODE), 1'b0);
            walk_depth--;
         end
         send_word(byte_rev(TOK_END), 1'b0);
      end
      // trailing words land after the end, mostly ignored
      repeat ($urandom_range(0, 3)) send_word($urandom, 1'b0);
   endtask

   // Stop sending and wait until every queued result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(input logic [23:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_words  = value;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic dir_row_type open_row(input logic [31:0] raw,
                                            input logic restart);
      open_row         = '0;
      open_row.raw     = raw;
      open_row.restart = restart;
   endfunction

   function automatic dir_row_type typed_row(
      input logic [31:0] raw, input logic restart, input kind_type kind,
      input logic [3:0] depth, input logic [31:0] len, input logic [31:0] off,
      input logic [31:0] value, input logic [2:0] nb, input logic last);
      typed_row                  = open_row(raw, restart);
      typed_row.typed            = 1'b1;
      typed_row.want.kind        = kind;
      typed_row.want.depth       = depth;
      typed_row.want.prop_length = len;
      typed_row.want.name_offset = off;
      typed_row.want.value_word  = value;
      typed_row.want.valid_bytes = nb;
      typed_row.want.last        = last;
   endfunction

   // Receiver: hold off for one long stretch on request, otherwise stall on
   // a pattern that changes at random intervals.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = LONG_HOLD;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            flow_mode = flow_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (flow_mode)
            FLOW_FREE:  rsp_stall <= 1'b0;
            FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:    rsp_stall <= ((mode_left % 7) < 3);
         endcase
      end
   end

   // Compare each accepted result transaction against the oldest expectation.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, value word", rsp_value_word, '0);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_kind !== want.kind)
               report_mismatch("kind", rsp_kind, want.kind);
            if (rsp_depth !== want.depth)
               report_mismatch("depth", rsp_depth, want.depth);
            if (rsp_prop_length !== want.prop_length)
               report_mismatch("prop_length", rsp_prop_length, want.prop_length);
            if (rsp_name_offset !== want.name_offset)
               report_mismatch("name_offset", rsp_name_offset, want.name_offset);
            if (rsp_value_word !== want.value_word)
               report_mismatch("value_word", rsp_value_word, want.value_word);
            if (rsp_valid_bytes !== want.valid_bytes)
               report_mismatch("valid_bytes", rsp_valid_bytes, want.valid_bytes);
            if (rsp_last !== want.last)
               report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   initial begin
      // Directed walk: one node with a full and an empty property, nesting,
      // end-node underflow, an unknown token, restart and the end token.
      dir_rows[0]  = typed_row(byte_rev(TOK_BEGIN_NODE), 1'b0, K_BEGIN, 4'd1, 0, 0,
                               TOK_BEGIN_NODE, 3'd0, 1'b0);
      dir_rows[1]  = typed_row(32'h6463_6261, 1'b0, K_NAME, 4'd1, 0, 0,
                               32'h6162_6364, 3'd4, 1'b0);
      dir_rows[2]  = typed_row(32'h7AFF_0065, 1'b0, K_NAME, 4'd1, 0, 0,
                               32'h6500_FF7A, 3'd1, 1'b1);
      dir_rows[3]  = typed_row(byte_rev(TOK_PROP), 1'b0, K_PROP, 4'd1, 0, 0,
                               TOK_PROP, 3'd0, 1'b0);
      dir_rows[4]  = typed_row(32'h0500_0000, 1'b0, K_LENGTH, 4'd1, 5, 0,
                               32'h0000_0005, 3'd0, 1'b0);
      dir_rows[5]  = typed_row(32'hFFFF_FFFF, 1'b0, K_NAMEOFF, 4'd1, 5, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 3'd0, 1'b0);
      dir_rows[6]  = typed_row(32'h0000_0000, 1'b0, K_DATA, 4'd1, 5, 32'hFFFF_FFFF,
                               32'h0000_0000, 3'd4, 1'b0);
      dir_rows[7]  = typed_row(32'hFFFF_FFFF, 1'b0, K_DATA, 4'd1, 5, 32'hFFFF_FFFF,
                               32'hFFFF_FFFF, 3'd1, 1'b1);
      dir_rows[8]  = open_row(byte_rev(TOK_PROP), 1'b0);
      dir_rows[9]  = open_row(32'h0000_0000, 1'b0);
      dir_rows[10] = open_row(32'h7856_3412, 1'b0);
      dir_rows[11] = open_row(byte_rev(TOK_NOP), 1'b0);
      dir_rows[12] = open_row(byte_rev(TOK_BEGIN_NODE), 1'b0);
      dir_rows[13] = open_row(32'h0000_0000, 1'b0);
      dir_rows[14] = open_row(byte_rev(TOK_PROP), 1'b0);
      dir_rows[15] = open_row(32'h0300_0000, 1'b0);
      dir_rows[16] = open_row(32'h0C00_0000, 1'b0);
      dir_rows[17] = open_row(32'hA5A5_A5A5, 1'b0);
      dir_rows[18] = open_row(byte_rev(TOK_END_NODE), 1'b0);
      dir_rows[19] = open_row(byte_rev(TOK_END_NODE), 1'b0);
      dir_rows[20] = typed_row(byte_rev(TOK_END_NODE), 1'b0, K_ERROR, 4'd0, 3, 12,
                               TOK_END_NODE, 3'd0, 1'b0);
      dir_rows[21] = typed_row(32'h5A5A_5A5A, 1'b0, K_IGNORED, 4'd0, 3, 12,
                               32'h5A5A_5A5A, 3'd0, 1'b0);
      dir_rows[22] = typed_row(32'h0700_0000, 1'b1, K_ERROR, 4'd0, 0, 0,
                               32'h0000_0007, 3'd0, 1'b0);
      dir_rows[23] = typed_row(byte_rev(TOK_END), 1'b1, K_END, 4'd0, 0, 0,
                               TOK_END, 3'd0, 1'b0);
      dir_rows[24] = typed_row(byte_rev(TOK_NOP), 1'b0, K_IGNORED, 4'd0, 0, 0,
                               TOK_NOP, 3'd0, 1'b0);
      foreach (kind_seen[i]) kind_seen[i] = 0;
      clear_parse_state();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Walk the table; on hand-checked rows replace the predicted result.
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].raw, dir_rows[i].restart);
         if (dir_rows[i].typed)
            pending_results[pending_results.size() - 1] = dir_rows[i].want;
      end
      drain();

      // Random blocks at the reset limit. Partway in, hold the receiver off
      // long enough for the block to back up and stall its input; later,
      // pause the sender until the result queue runs dry.
      while (words_sent < 500) begin
         send_block();
         if (!hold_done && words_sent > 200) begin
            hold_req  = 1'b1;
            hold_done = 1'b1;
         end
      end
      drain();
      while (words_sent < 800) send_block();
      drain();

      // Limit of zero: every word comes back ignored, restart or not.
      write_limit('0);
      repeat (30) send_word($urandom, 1'(($urandom_range(0, 1))));
      drain();

      // Limit of one, then a small random limit: blocks get cut off early.
      write_limit(24'd1);
      while (words_sent < 1000) send_block();
      drain();
      small_limit = $urandom_range(2, 40);
      write_limit(24'(small_limit));
      while (words_sent < 1250) send_block();
      drain();

      // Back to the full limit for the last stretch.
      write_limit(LIMIT_RESET);
      while (words_sent < 1700) send_block();
      drain();

      $display("Covered %0d words (%0d parsed, %0d ignored) at limits 0, 1, %0d and full,",
               words_sent, parsed_words, kind_seen[K_IGNORED], small_limit);
      $display("  with %0d errors, %0d ends, nesting up to %0d; %0d results checked.",
               kind_seen[K_ERROR], kind_seen[K_END], deepest, results_checked);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Hard stop, far beyond the slowest legitimate run.
   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
